// ----- design/dpv_pkg.sv -----
// ----------------------------------------------------------------------------
// dpv_pkg
// Shared types and constants of the Doppler peak velocity unit.
// ----------------------------------------------------------------------------
package dpv_pkg;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned GATE_OUT_W  = 10;
  localparam int unsigned PEAK_OUT_W  = 9;
  localparam int unsigned POWER_W     = 32;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AOM_BIN         = 3'd0,
    CFG_BAND_HALF_WIDTH = 3'd1,
    CFG_FREQ_STEP_HZ    = 3'd2,
    CFG_AOM_FREQ_HZ     = 3'd3,
    CFG_VELOCITY_GAIN   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [8:0]  aom_bin;
    logic [8:0]  band_half_width;
    logic [23:0] freq_step_hz;
    logic [29:0] aom_freq_hz;
    logic [31:0] velocity_gain;
  } cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIFF,
    BK_MUL,
    BK_SUM,
    BK_OUT
  } back_state_e;

endpackage

// ----- design/dpv_if.sv -----
// ----------------------------------------------------------------------------
// dpv_in_if / dpv_out_if
// Valid/ready channels for spectrum bins in and gate results out.
// ----------------------------------------------------------------------------
interface dpv_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] bin_power;
  logic        last_bin;

  modport source (output valid, req_type, bin_power, last_bin, input ready);
  modport sink   (input valid, req_type, bin_power, last_bin, output ready);
endinterface

interface dpv_out_if;
  logic               valid;
  logic               ready;
  logic [9:0]         gate_index;
  logic [8:0]         peak_bin;
  logic signed [31:0] velocity_mm_s;

  modport source (output valid, gate_index, peak_bin, velocity_mm_s, input ready);
  modport sink   (input valid, gate_index, peak_bin, velocity_mm_s, output ready);
endinterface

// ----- design/dpv_ram.sv -----
// ----------------------------------------------------------------------------
// dpv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dpv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/dpv_queue.sv -----
// ----------------------------------------------------------------------------
// dpv_queue
// Short FIFO of finished gates between peak search and velocity math.
// ----------------------------------------------------------------------------
module dpv_queue #(
  parameter int unsigned WIDTH = 19,
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             push_data_i,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             head_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PW   = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  assign head_o  = slot_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

// ----- design/dpv_front.sv -----
// ----------------------------------------------------------------------------
// dpv_front
// Bin intake: background store, windowed subtraction and peak search.
// ----------------------------------------------------------------------------
module dpv_front #(
  parameter int unsigned NUM_BINS  = 512,
  parameter int unsigned MAX_GATES = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  dpv_in_if.sink                                in_i,
  input  dpv_pkg::cfg_t                         cfg_i,
  input  logic [dpv_pkg::QCNT_W-1:0]            q_count_i,
  output logic                                  push_o,
  output logic [dpv_pkg::GATE_OUT_W+$clog2(NUM_BINS)-1:0] push_data_o
);

  localparam int unsigned BW = $clog2(NUM_BINS);
  localparam int unsigned CW = $clog2(NUM_BINS + 1);
  localparam int unsigned GW = $clog2(MAX_GATES);
  localparam int unsigned XW = (CW > 10) ? CW : 10;
  localparam int unsigned QW = dpv_pkg::QCNT_W + 1;

  logic              accept;
  logic              bin_ok, in_win;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [XW-1:0]     cnt_x, lo_x, hi_x;
  logic [9:0]        lo10, hi10;
  logic [31:0]       bg_rdata;

  logic              s1_valid_q, s1_type_q, s1_last_q, s1_inwin_q;
  logic [BW-1:0]     s1_bin_q;
  logic [31:0]       s1_power_q;

  logic signed [32:0] max_q, max_d, diff;
  logic [BW-1:0]     max_bin_q, max_bin_d, peak;
  logic              started_q, started_d, upd;
  logic [GW-1:0]     gate_q, gate_d;
  logic [GW+9:0]     gate_ext;

  // clipped window [lo, hi)
  always_comb begin
    lo10 = (cfg_i.aom_bin > cfg_i.band_half_width) ?
           ({1'b0, cfg_i.aom_bin} - {1'b0, cfg_i.band_half_width}) : 10'd0;
    hi10 = {1'b0, cfg_i.aom_bin} + {1'b0, cfg_i.band_half_width};
    lo_x = XW'(lo10);
    if (lo_x > XW'(NUM_BINS - 1)) begin
      lo_x = XW'(NUM_BINS - 1);
    end
    hi_x = XW'(hi10);
    if (hi_x > XW'(NUM_BINS)) begin
      hi_x = XW'(NUM_BINS);
    end
  end

  assign cnt_x  = XW'(cnt_q);
  assign bin_ok = (cnt_q < CW'(NUM_BINS));
  assign in_win = bin_ok && (cnt_x >= lo_x) && (cnt_x < hi_x);

  // reserve room for a gate that may finish in stage 1 next cycle
  assign push_o     = s1_valid_q && s1_type_q && s1_last_q;
  assign in_i.ready = ((QW'(q_count_i) + QW'(push_o)) < QW'(dpv_pkg::QUEUE_DEPTH));
  assign accept     = in_i.valid && in_i.ready;

  dpv_ram #(
    .WIDTH (dpv_pkg::POWER_W),
    .DEPTH (NUM_BINS)
  ) u_bg_ram (
    .clk_i   (clk_i),
    .we_i    (accept && !in_i.req_type && bin_ok),
    .waddr_i (cnt_q[BW-1:0]),
    .wdata_i (in_i.bin_power),
    .re_i    (accept && in_i.req_type && in_win),
    .raddr_i (cnt_q[BW-1:0]),
    .rdata_o (bg_rdata)
  );

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (in_i.last_bin) begin
        cnt_d = '0;
      end else if (bin_ok) begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  // stage 1: subtract background and track first strict maximum
  always_comb begin
    diff      = $signed({1'b0, s1_power_q}) - $signed({1'b0, bg_rdata});
    upd       = s1_valid_q && s1_type_q && s1_inwin_q && (!started_q || diff > max_q);
    max_d     = max_q;
    max_bin_d = max_bin_q;
    started_d = started_q;
    gate_d    = gate_q;
    if (upd) begin
      max_d     = diff;
      max_bin_d = s1_bin_q;
      started_d = 1'b1;
    end
    if (upd) begin
      peak = s1_bin_q;
    end else if (started_q) begin
      peak = max_bin_q;
    end else begin
      peak = lo_x[BW-1:0];
    end
    if (s1_valid_q && s1_last_q) begin
      max_d     = '0;
      max_bin_d = '0;
      started_d = 1'b0;
      if (s1_type_q) begin
        gate_d = (gate_q == GW'(MAX_GATES - 1)) ? '0 : gate_q + GW'(1);
      end else begin
        gate_d = '0;
      end
    end
  end

  assign gate_ext    = {10'd0, gate_q};
  assign push_data_o = {gate_ext[9:0], peak};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
      max_q      <= '0;
      max_bin_q  <= '0;
      started_q  <= 1'b0;
      gate_q     <= '0;
    end else begin
      cnt_q      <= cnt_d;
      s1_valid_q <= accept;
      max_q      <= max_d;
      max_bin_q  <= max_bin_d;
      started_q  <= started_d;
      gate_q     <= gate_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_type_q  <= in_i.req_type;
      s1_last_q  <= in_i.last_bin;
      s1_inwin_q <= in_win;
      s1_bin_q   <= cnt_q[BW-1:0];
      s1_power_q <= in_i.bin_power;
    end
  end

endmodule

// ----- design/dpv_back.sv -----
// ----------------------------------------------------------------------------
// dpv_back
// Per-gate velocity: frequency offset times gain, rounded and saturated.
// ----------------------------------------------------------------------------
module dpv_back #(
  parameter int unsigned NUM_BINS = 512
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  dpv_pkg::cfg_t                                     cfg_i,
  input  logic                                              q_empty_i,
  input  logic [dpv_pkg::GATE_OUT_W+$clog2(NUM_BINS)-1:0]   q_head_i,
  output logic                                              q_pop_o,
  dpv_out_if.source                                         out_o
);

  localparam int unsigned BW = $clog2(NUM_BINS);
  localparam int unsigned FW = BW + 24;
  localparam int unsigned MW = (FW > 30) ? FW : 30;
  localparam int unsigned PW = MW + 16;
  localparam int unsigned SW = MW + 18;
  localparam int unsigned RW = SW - 16;

  dpv_pkg::back_state_e state_q, state_d;

  logic [BW-1:0]     peak_q;
  logic [9:0]        gate_q;
  logic [FW-1:0]     f_q;
  logic [MW-1:0]     f_x, a_x, mag_q;
  logic              pos_q;
  logic [PW-1:0]     hi_q, lo_q;
  logic [SW-1:0]     sum;
  logic [RW-1:0]     m;
  logic [31:0]       vel_d, vel_q;
  logic [BW+8:0]     peak_ext;

  assign q_pop_o = (state_q == dpv_pkg::BK_IDLE) && !q_empty_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      dpv_pkg::BK_IDLE: if (!q_empty_i) state_d = dpv_pkg::BK_DIFF;
      dpv_pkg::BK_DIFF: state_d = dpv_pkg::BK_MUL;
      dpv_pkg::BK_MUL:  state_d = dpv_pkg::BK_SUM;
      dpv_pkg::BK_SUM:  state_d = dpv_pkg::BK_OUT;
      dpv_pkg::BK_OUT:  if (out_o.ready) state_d = dpv_pkg::BK_IDLE;
      default:          state_d = dpv_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpv_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign f_x = MW'(f_q);
  assign a_x = MW'(cfg_i.aom_freq_hz);

  // magnitude rounded half up: (hi + lo/2^16 + 2^15) / 2^16
  always_comb begin
    sum = SW'(hi_q) + SW'(lo_q[PW-1:16]) + SW'(32'h0000_8000);
    m   = sum[SW-1:16];
    if (pos_q) begin
      vel_d = (m >= RW'(32'h8000_0000)) ? 32'h8000_0000 : (32'd0 - m[31:0]);
    end else begin
      vel_d = (m > RW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : m[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      peak_q <= q_head_i[BW-1:0];
      gate_q <= q_head_i[BW+9:BW];
      f_q    <= FW'(q_head_i[BW-1:0]) * FW'(cfg_i.freq_step_hz);
    end
    if (state_q == dpv_pkg::BK_DIFF) begin
      pos_q <= (f_x > a_x);
      mag_q <= (f_x > a_x) ? (f_x - a_x) : (a_x - f_x);
    end
    if (state_q == dpv_pkg::BK_MUL) begin
      hi_q <= PW'(mag_q) * PW'(cfg_i.velocity_gain[31:16]);
      lo_q <= PW'(mag_q) * PW'(cfg_i.velocity_gain[15:0]);
    end
    if (state_q == dpv_pkg::BK_SUM) begin
      vel_q <= vel_d;
    end
  end

  assign peak_ext            = {9'd0, peak_q};
  assign out_o.valid         = (state_q == dpv_pkg::BK_OUT);
  assign out_o.gate_index    = gate_q;
  assign out_o.peak_bin      = peak_ext[8:0];
  assign out_o.velocity_mm_s = $signed(vel_q);

endmodule

// ----- design/doppler_peak_velocity_unit.sv -----
// ----------------------------------------------------------------------------
// doppler_peak_velocity_unit
// Background-subtracted spectral peak search and line-of-sight velocity.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_i      in   valid/ready    req_type, bin_power[31:0], last_bin
//  out_o     out  valid/ready    gate_index[9:0], peak_bin[8:0], velocity_mm_s[31:0]
//  cfg       in   cfg_we_i       cfg_idx_i[2:0], cfg_data_i[31:0]
//
//  Bins are taken one per cycle while in_i.ready is high; the peak search is a
//  two-stage pipe around the background RAM's registered read.
//  Each finished gate passes the velocity sequencer's DIFF, MUL, SUM and
//  OUT states, held in OUT on an output stall; a 4-entry queue absorbs
//  bursts of short gates. in_i.ready drops only when that queue could overflow.
//  Reset clears counters and search state; background RAM is not cleared.
// ----------------------------------------------------------------------------
module doppler_peak_velocity_unit #(
  parameter int unsigned NUM_BINS  = 512,
  parameter int unsigned MAX_GATES = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  dpv_in_if.sink                           in_i,
  dpv_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [dpv_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dpv_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned QDW = dpv_pkg::GATE_OUT_W + $clog2(NUM_BINS);

  dpv_pkg::cfg_t cfg_q;

  logic                        push, pop, q_empty;
  logic [QDW-1:0]              push_data, q_head;
  logic [dpv_pkg::QCNT_W-1:0]  q_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.aom_bin         <= 9'd0;
      cfg_q.band_half_width <= 9'd16;
      cfg_q.freq_step_hz    <= 24'd1;
      cfg_q.aom_freq_hz     <= 30'd0;
      cfg_q.velocity_gain   <= 32'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dpv_pkg::CFG_AOM_BIN:         cfg_q.aom_bin         <= cfg_data_i[8:0];
        dpv_pkg::CFG_BAND_HALF_WIDTH: cfg_q.band_half_width <= cfg_data_i[8:0];
        dpv_pkg::CFG_FREQ_STEP_HZ:    cfg_q.freq_step_hz    <= cfg_data_i[23:0];
        dpv_pkg::CFG_AOM_FREQ_HZ:     cfg_q.aom_freq_hz     <= cfg_data_i[29:0];
        dpv_pkg::CFG_VELOCITY_GAIN:   cfg_q.velocity_gain   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dpv_front #(
    .NUM_BINS  (NUM_BINS),
    .MAX_GATES (MAX_GATES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_q),
    .q_count_i   (q_count),
    .push_o      (push),
    .push_data_o (push_data)
  );

  dpv_queue #(
    .WIDTH (QDW),
    .DEPTH (dpv_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (q_head),
    .empty_o     (q_empty),
    .count_o     (q_count)
  );

  dpv_back #(
    .NUM_BINS (NUM_BINS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .q_pop_o   (pop),
    .out_o     (out_o)
  );

endmodule
